// ===== rtl/atlp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Accession/taxid line parser package
// Shared widths, status codes, character constants, request and result
// types, and small character class helpers.
// ----------------------------------------------------------------------------
package atlp_pkg;

  localparam int ACC_BUFFER_BYTES = 64;
  localparam int ACC_IDX_W        = $clog2(ACC_BUFFER_BYTES);
  localparam int DATA_W           = 8;
  localparam int TAXID_W          = 32;
  localparam int ACC_LEN_W        = 6;
  localparam int HEADER_LEN       = 9;

  localparam logic [DATA_W-1:0] CH_TAB   = 8'd9;
  localparam logic [DATA_W-1:0] CH_NL    = 8'd10;
  localparam logic [DATA_W-1:0] CH_CR    = 8'd13;
  localparam logic [DATA_W-1:0] CH_SPACE = 8'd32;
  localparam logic [DATA_W-1:0] CH_DOT   = 8'd46;
  localparam logic [DATA_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [DATA_W-1:0] CH_NINE  = 8'd57;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_OK_LEAD      = 4'd1,
    ST_EMPTY        = 4'd2,
    ST_TOO_LONG     = 4'd3,
    ST_HEADER       = 4'd4,
    ST_FATAL_NO_TAB = 4'd5,
    ST_MISMATCH     = 4'd6,
    ST_UNVERSIONED  = 4'd7,
    ST_BAD_VERSION  = 4'd8,
    ST_NO_TAB2      = 4'd9,
    ST_BAD_TAXID    = 4'd10,
    ST_NO_TAB3      = 4'd11,
    ST_EXTRA_FIELD  = 4'd12,
    ST_INCOMPLETE   = 4'd13
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              end_of_stream;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [TAXID_W-1:0]   taxid;
    logic [ACC_LEN_W-1:0] accession_length;
  } out_item_t;

  typedef struct packed {
    logic                 wr_en;
    logic [ACC_IDX_W-1:0] wr_addr;
    logic [DATA_W-1:0]    wr_data;
    logic [ACC_IDX_W-1:0] rd_addr;
  } store_req_t;

  function automatic logic [DATA_W-1:0] header_char(input logic [3:0] idx);
    logic [DATA_W-1:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h61;
      4'd1:    ch = 8'h63;
      4'd2:    ch = 8'h63;
      4'd3:    ch = 8'h65;
      4'd4:    ch = 8'h73;
      4'd5:    ch = 8'h73;
      4'd6:    ch = 8'h69;
      4'd7:    ch = 8'h6f;
      4'd8:    ch = 8'h6e;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_ws(input logic [DATA_W-1:0] ch);
    return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [DATA_W-1:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/accession_taxid_line_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Accession/taxid line parser
// Parses tab-separated accession, accession.version and taxid lines from a
// byte stream and gives one status request per line.
// ----------------------------------------------------------------------------
//  Channel  Signals                        Moves
//  in       in_valid, in_stall, in_data    one byte or end of stream
//  out      out_valid, out_stall, out_data status, taxid, accession length
//
//  One byte is taken per cycle unless the output stalls. A byte is held in
//  the input register, and its status is registered in the result register
//  by combinational parse logic between the two; the accession store read is
//  registered ahead of the compare. Reset is synchronous and returns the
//  block to line start and clears a fatal halt. A stalled output holds its
//  request and, with the input register full, stalls the input.
module accession_taxid_line_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  atlp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output atlp_pkg::out_item_t out_data
);
  import atlp_pkg::*;

  logic        q_valid;
  in_item_t    q_item;
  logic        advance;
  logic        in_accept;
  logic        res_valid;
  out_item_t   res;
  logic        halted;
  store_req_t  store_req;
  logic [DATA_W-1:0] rd_data;

  assign advance   = q_valid && (!out_valid || !out_stall);
  assign in_stall  = q_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_accept) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      q_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data <= res;
    end
  end

  atlp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (q_item),
    .rd_data   (rd_data),
    .store_req (store_req),
    .res_valid (res_valid),
    .res       (res),
    .halted    (halted)
  );

  atlp_store u_store (
    .clk       (clk),
    .store_req (store_req),
    .rd_data   (rd_data)
  );

`ifndef SYNTH
  a_fatal_halts: assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid && (res.status == ST_FATAL_NO_TAB)) |=> halted)
    else $error("fatal status did not halt the parser");

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    halted |-> !res_valid)
    else $error("halted parser produced a status");

  a_taxid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status != ST_OK) && (out_data.status != ST_OK_LEAD))
      |-> (out_data.taxid == '0))
    else $error("taxid nonzero on an error status");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !advance)
    else $error("parser advanced while the result register was held");
`endif

endmodule
`default_nettype wire

// ===== rtl/atlp_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Accession store
// Single-port-write, single-port-read byte memory that holds the accession
// of the current line. Read data is registered.
// ----------------------------------------------------------------------------
module atlp_store (
  input  logic                      clk,
  input  atlp_pkg::store_req_t      store_req,
  output logic [atlp_pkg::DATA_W-1:0] rd_data
);
  import atlp_pkg::*;

  logic [DATA_W-1:0] mem [ACC_BUFFER_BYTES];

  always_ff @(posedge clk) begin
    if (store_req.wr_en) begin
      mem[store_req.wr_addr] <= store_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[store_req.rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/atlp_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line parser core
// Holds the per-line parse state and decides, for the byte in the input
// register, the next state, the store access and the optional status.
// ----------------------------------------------------------------------------
module atlp_parse (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  atlp_pkg::in_item_t     item,
  input  logic [atlp_pkg::DATA_W-1:0] rd_data,
  output atlp_pkg::store_req_t   store_req,
  output logic                   res_valid,
  output atlp_pkg::out_item_t    res,
  output logic                   halted
);
  import atlp_pkg::*;

  typedef enum logic [5:0] {
    PH_LINE = 6'b000001,
    PH_ACC  = 6'b000010,
    PH_CMP  = 6'b000100,
    PH_VER  = 6'b001000,
    PH_TAX  = 6'b010000,
    PH_SKIP = 6'b100000
  } phase_t;

  phase_t               phase, phase_next;
  logic [ACC_IDX_W-1:0] count, count_next;
  logic [ACC_IDX_W-1:0] cidx, cidx_next;
  logic [TAXID_W-1:0]   taxid_sum, taxid_sum_next;
  logic                 lead, lead_next;
  logic                 hdr_match, hdr_match_next;
  logic                 halted_next;
  logic                 new_line;
  logic                 fail_hit;
  logic                 wr_req;
  status_t              res_status;
  logic [DATA_W-1:0]    ch;

  always_comb begin
    ch             = item.data_byte;
    phase_next     = phase;
    count_next     = count;
    cidx_next      = cidx;
    taxid_sum_next = taxid_sum;
    lead_next      = lead;
    hdr_match_next = hdr_match;
    halted_next    = halted;
    new_line       = 1'b0;
    fail_hit       = 1'b0;
    wr_req         = 1'b0;
    res_valid      = 1'b0;
    res_status     = ST_OK;

    if (!halted) begin
      if (item.end_of_stream) begin
        new_line = 1'b1;
        unique case (phase)
          PH_LINE: begin
            res_valid  = lead;
            res_status = ST_INCOMPLETE;
          end
          PH_ACC: begin
            res_valid  = 1'b1;
            res_status = ST_INCOMPLETE;
          end
          PH_CMP: begin
            res_valid  = 1'b1;
            res_status = ST_UNVERSIONED;
          end
          PH_VER: begin
            res_valid  = 1'b1;
            res_status = ST_NO_TAB2;
          end
          PH_TAX: begin
            res_valid  = 1'b1;
            res_status = ST_NO_TAB3;
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end else begin
        unique case (phase)
          PH_LINE: begin
            if (ch == CH_NL) begin
              res_valid  = 1'b1;
              res_status = ST_EMPTY;
              new_line   = 1'b1;
            end else if (is_ws(ch)) begin
              lead_next = 1'b1;
            end else begin
              wr_req         = 1'b1;
              count_next     = ACC_IDX_W'(1);
              hdr_match_next = (ch == header_char(4'd0));
              phase_next     = PH_ACC;
            end
          end
          PH_ACC: begin
            if (is_ws(ch)) begin
              if ((count == ACC_IDX_W'(HEADER_LEN)) && hdr_match) begin
                fail_hit   = 1'b1;
                res_status = ST_HEADER;
              end else if (ch == CH_TAB) begin
                cidx_next  = '0;
                phase_next = PH_CMP;
              end else begin
                res_valid   = 1'b1;
                res_status  = ST_FATAL_NO_TAB;
                halted_next = 1'b1;
              end
            end else if (count == ACC_IDX_W'(ACC_BUFFER_BYTES - 1)) begin
              fail_hit   = 1'b1;
              res_status = ST_TOO_LONG;
            end else begin
              wr_req         = 1'b1;
              count_next     = count + ACC_IDX_W'(1);
              hdr_match_next = hdr_match && (count < ACC_IDX_W'(HEADER_LEN)) &&
                               (ch == header_char(count[3:0]));
            end
          end
          PH_CMP: begin
            if (is_ws(ch)) begin
              fail_hit   = 1'b1;
              res_status = ST_UNVERSIONED;
            end else if (cidx >= count) begin
              if (ch == CH_DOT) begin
                phase_next = PH_VER;
              end else begin
                fail_hit   = 1'b1;
                res_status = ST_UNVERSIONED;
              end
            end else if (ch != rd_data) begin
              fail_hit   = 1'b1;
              res_status = ST_MISMATCH;
            end else begin
              cidx_next = cidx + ACC_IDX_W'(1);
            end
          end
          PH_VER: begin
            if (ch == CH_TAB) begin
              phase_next = PH_TAX;
            end else if (is_ws(ch)) begin
              fail_hit   = 1'b1;
              res_status = ST_NO_TAB2;
            end else if (!is_digit(ch)) begin
              fail_hit   = 1'b1;
              res_status = ST_BAD_VERSION;
            end
          end
          PH_TAX: begin
            if (ch == CH_NL) begin
              res_valid  = 1'b1;
              res_status = lead ? ST_OK_LEAD : ST_OK;
              new_line   = 1'b1;
            end else if (ch == CH_TAB) begin
              fail_hit   = 1'b1;
              res_status = ST_EXTRA_FIELD;
            end else if (is_ws(ch)) begin
              fail_hit   = 1'b1;
              res_status = ST_NO_TAB3;
            end else if (!is_digit(ch)) begin
              fail_hit   = 1'b1;
              res_status = ST_BAD_TAXID;
            end else begin
              taxid_sum_next = (taxid_sum << 3) + (taxid_sum << 1) +
                               TAXID_W'(ch[3:0]);
            end
          end
          default: begin
            if (ch == CH_NL) begin
              new_line = 1'b1;
            end
          end
        endcase
      end
    end

    if (fail_hit) begin
      res_valid = 1'b1;
      if (ch == CH_NL) begin
        new_line = 1'b1;
      end else begin
        phase_next = PH_SKIP;
      end
    end

    if (new_line) begin
      phase_next     = PH_LINE;
      count_next     = '0;
      cidx_next      = '0;
      taxid_sum_next = '0;
      lead_next      = 1'b0;
    end
  end

  always_comb begin
    res.status           = res_status;
    res.taxid            = ((res_status == ST_OK) || (res_status == ST_OK_LEAD)) ?
                           taxid_sum : '0;
    res.accession_length = ACC_LEN_W'(count);
    store_req.wr_en      = advance && wr_req;
    store_req.wr_addr    = count;
    store_req.wr_data    = ch;
    store_req.rd_addr    = advance ? cidx_next : cidx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LINE;
      count     <= '0;
      cidx      <= '0;
      taxid_sum <= '0;
      lead      <= 1'b0;
      hdr_match <= 1'b0;
      halted    <= 1'b0;
    end else if (advance) begin
      phase     <= phase_next;
      count     <= count_next;
      cidx      <= cidx_next;
      taxid_sum <= taxid_sum_next;
      lead      <= lead_next;
      hdr_match <= hdr_match_next;
      halted    <= halted_next;
    end
  end

endmodule
`default_nettype wire
